// ===== rtl/core/tds_pkg.sv =====
// Package: shared types and constants for the tridiagonal solver.
package tds_pkg;

  localparam int MaxRows = 64;
  localparam int IdxW    = $clog2(MaxRows);
  localparam int CntW    = $clog2(MaxRows + 1);

  localparam logic signed [63:0] QMax = 64'sd2147483647;
  localparam logic signed [63:0] QMin = -64'sd2147483648;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_MUL_C,
    ST_PIV,
    ST_MUL_D,
    ST_DIV_C,
    ST_DIV_D,
    ST_WR,
    ST_BRD,
    ST_BMUL,
    ST_BOUT
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > QMax) r = 32'sh7FFFFFFF;
    else if (v < QMin) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] qsub(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] t;
    t = 64'(a) - 64'(b);
    return sat32(t);
  endfunction

endpackage

// ===== rtl/core/tds_if.sv =====
// Interfaces: valid/ready channels for rows and for solution values.
interface tds_row_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sub_coef;
  logic signed [31:0] diag_coef;
  logic signed [31:0] super_coef;
  logic signed [31:0] rhs_value;
  logic               last_row;
  modport source (output valid, sub_coef, diag_coef, super_coef, rhs_value, last_row,
                  input ready);
  modport sink (input valid, sub_coef, diag_coef, super_coef, rhs_value, last_row,
                output ready);
endinterface

interface tds_sol_if;
  logic               valid;
  logic               ready;
  logic [5:0]         row_index;
  logic signed [31:0] solution;
  logic               final_result;
  logic               singular;
  logic               rows_dropped;
  modport source (output valid, row_index, solution, final_result, singular, rows_dropped,
                  input ready);
  modport sink (input valid, row_index, solution, final_result, singular, rows_dropped,
                output ready);
endinterface

// ===== rtl/core/tridiagonal_system_solver_core.sv =====
// Top level: Thomas-algorithm tridiagonal solver, Q16.16, shared ALU.
// Each row: control and multiply steps plus two divides (start, 48 bit-serial
//   steps, done); in_ready stays low until a row is through, so a new row is
//   not taken before the last one is done; a zero pivot shortens each divide.
// Back substitution: read, multiply (not for topmost), emit; waits for out_ready.
// Synchronous active-low reset clears the sequencer, counts and flags.
module tridiagonal_system_solver_core import tds_pkg::*; (
  input logic   clk,
  input logic   rst_n,
  tds_row_if.sink   in_row,
  tds_sol_if.source out_sol
);

  state_t state_r, state_nxt;

  // captured request
  logic signed [31:0] a_r, b_r, c_r, d_r;
  logic               last_r;
  logic signed [31:0] pc_r, pd_r, piv_r, t_r, cq_r;
  logic [CntW-1:0]    rows_r;
  logic               sing_r, ovf_r;
  logic signed [31:0] back_r;
  logic [IdxW-1:0]    bidx_r;
  logic               first_r;

  // output register
  logic               ov_r;
  logic [5:0]         oidx_r;
  logic signed [31:0] osol_r;
  logic               ofin_r;

  alu_ctl_t           actl;
  logic signed [31:0] aa, ab, ares;
  logic               adone;

  logic               st_we;
  logic [IdxW-1:0]    st_raddr;
  logic signed [31:0] st_rc, st_rd;

  logic acc_in;
  assign acc_in = in_row.valid && in_row.ready;
  assign in_row.ready = (state_r == ST_IDLE);

  tds_alu u_alu (
    .clk(clk), .rst_n(rst_n), .ctl(actl), .opa(aa), .opb(ab),
    .done(adone), .result(ares)
  );

  tds_store u_store (
    .clk(clk), .we(st_we), .waddr(rows_r[IdxW-1:0]), .wc(cq_r), .wd(ares),
    .raddr(st_raddr), .rc(st_rc), .rd(st_rd)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (acc_in) begin
        state_nxt = ST_RD;
      end
      ST_RD:    state_nxt = (rows_r == CntW'(MaxRows)) ?
                            (last_r ? ST_BRD : ST_IDLE) : ST_MUL_C;
      ST_MUL_C: if (adone) state_nxt = ST_PIV;
      ST_PIV:   state_nxt = ST_MUL_D;
      ST_MUL_D: if (adone) state_nxt = ST_DIV_C;
      ST_DIV_C: if (adone) state_nxt = ST_DIV_D;
      ST_DIV_D: if (adone) state_nxt = ST_WR;
      ST_WR:    state_nxt = last_r ? ST_BRD : ST_IDLE;
      ST_BRD:   state_nxt = ST_BMUL;
      ST_BMUL:  if (first_r || adone) state_nxt = ST_BOUT;
      ST_BOUT:  if (!ov_r) begin
        state_nxt = (bidx_r == '0) ? ST_IDLE : ST_BRD;
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // ALU requests and store controls
  logic started_r;
  always_comb begin
    actl.start = 1'b0;
    actl.op    = OP_MUL;
    aa         = a_r;
    ab         = pc_r;
    st_we      = 1'b0;
    st_raddr   = bidx_r;
    // previous row's ratios are read while idle so they are ready in ST_RD
    if (state_r == ST_IDLE || state_r == ST_RD) st_raddr = rows_r[IdxW-1:0] - IdxW'(1);
    unique case (state_r)
      ST_MUL_C: begin
        actl.start = !started_r;
        aa = a_r; ab = pc_r;
      end
      ST_MUL_D: begin
        actl.start = !started_r;
        aa = a_r; ab = pd_r;
      end
      ST_DIV_C: begin
        actl.start = !started_r;
        actl.op = OP_DIV;
        aa = c_r; ab = piv_r;
      end
      ST_DIV_D: begin
        actl.start = !started_r;
        actl.op = OP_DIV;
        aa = t_r; ab = piv_r;
      end
      ST_WR: st_we = 1'b0;
      ST_BMUL: begin
        actl.start = !started_r && !first_r;
        aa = st_rc; ab = back_r;
      end
      default: ;
    endcase
    if (state_r == ST_DIV_D && adone) st_we = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      rows_r    <= '0;
      sing_r    <= 1'b0;
      ovf_r     <= 1'b0;
      ov_r      <= 1'b0;
      started_r <= 1'b0;
      first_r   <= 1'b0;
      back_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_nxt != state_r) started_r <= 1'b0;
      else if (actl.start) started_r <= 1'b1;
      if (ov_r && out_sol.ready) ov_r <= 1'b0;
      unique case (state_r)
        ST_RD: begin
          if (rows_r == CntW'(MaxRows)) begin
            ovf_r <= 1'b1;
            if (last_r) begin
              bidx_r  <= IdxW'(rows_r - CntW'(1));
              first_r <= 1'b1;
            end
          end
        end
        ST_PIV: if (qsub(b_r, ares) == 32'sd0) sing_r <= 1'b1;
        ST_WR: begin
          rows_r <= rows_r + CntW'(1);
          if (last_r) begin
            bidx_r  <= rows_r[IdxW-1:0];
            first_r <= 1'b1;
          end
        end
        ST_BMUL: if (first_r || adone) begin
          ov_r   <= 1'b1;
          oidx_r <= 6'(bidx_r);
          ofin_r <= (bidx_r == '0);
          osol_r <= first_r ? st_rd : qsub(st_rd, ares);
          back_r <= first_r ? st_rd : qsub(st_rd, ares);
          first_r <= 1'b0;
        end
        ST_BOUT: if (!ov_r) begin
          if (bidx_r == '0) begin
            rows_r <= '0;
            sing_r <= 1'b0;
            ovf_r  <= 1'b0;
            back_r <= '0;
          end else begin
            bidx_r <= bidx_r - IdxW'(1);
          end
        end
        default: ;
      endcase
    end
    if (acc_in) begin
      a_r    <= (rows_r == '0) ? 32'sd0 : in_row.sub_coef;
      b_r    <= in_row.diag_coef;
      c_r    <= in_row.last_row ? 32'sd0 : in_row.super_coef;
      d_r    <= in_row.rhs_value;
      last_r <= in_row.last_row;
    end
    if (state_r == ST_RD) begin
      pc_r <= (rows_r == '0) ? 32'sd0 : st_rc;
      pd_r <= (rows_r == '0) ? 32'sd0 : st_rd;
    end
    if (state_r == ST_PIV) piv_r <= qsub(b_r, ares);
    if (state_r == ST_MUL_D && adone) t_r <= qsub(d_r, ares);
    if (state_r == ST_DIV_C && adone) cq_r <= ares;
  end

  assign out_sol.valid        = ov_r;
  assign out_sol.row_index    = oidx_r;
  assign out_sol.solution     = osol_r;
  assign out_sol.final_result = ofin_r;
  assign out_sol.singular     = sing_r;
  assign out_sol.rows_dropped = ovf_r;

  a_no_ready_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_sol.valid |-> !in_row.ready) else $error("ready while emitting");
  a_rows_cap: assert property (@(posedge clk) disable iff (!rst_n)
    rows_r <= CntW'(MaxRows)) else $error("row count past capacity");
  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_sol.valid && out_sol.ready && out_sol.final_result) |=> ##1 (rows_r == '0))
    else $error("run not cleared");

endmodule

// ===== rtl/core/tds_alu.sv =====
// Shared arithmetic unit: Q16.16 multiply (registered result) or restoring divide.
module tds_alu import tds_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  alu_ctl_t           ctl,
  input  logic signed [31:0] opa,
  input  logic signed [31:0] opb,
  output logic               done,
  output logic signed [31:0] result
);

  logic               busy_r, busy_nxt;
  logic [5:0]         cnt_r, cnt_nxt;
  logic [47:0]        rem_r, rem_nxt;
  logic [47:0]        quo_r, quo_nxt;
  logic [31:0]        den_r, den_nxt;
  logic               neg_r, neg_nxt;
  logic               done_r, done_nxt;
  logic signed [31:0] res_r, res_nxt;

  logic signed [63:0] prod, prnd;
  logic [48:0]        trial;
  logic [47:0]        num_mag;
  logic [31:0]        den_mag;

  always_comb begin
    prod    = 64'(opa) * 64'(opb);
    prnd    = (prod + 64'sd32768) >>> 16;
    num_mag = opa[31] ? (48'(~{{16{opa[31]}}, opa}) + 48'd1) << 16 : {16'h0, opa} << 16;
    den_mag = opb[31] ? 32'(-opb) : opb;
    trial   = {rem_r, quo_r[47]} - {17'h0, den_r};
  end

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    done_nxt = 1'b0;
    res_nxt  = res_r;
    if (ctl.start) begin
      unique case (ctl.op)
        OP_MUL: begin
          res_nxt  = sat32(prnd);
          done_nxt = 1'b1;
        end
        OP_DIV: begin
          if (opb == 32'sd0) begin
            res_nxt  = opa[31] ? 32'sh80000000 : (opa == 32'sd0 ? 32'sd0 : 32'sh7FFFFFFF);
            done_nxt = 1'b1;
          end else begin
            busy_nxt = 1'b1;
            cnt_nxt  = 6'd0;
            rem_nxt  = 48'h0;
            quo_nxt  = num_mag;
            den_nxt  = den_mag;
            neg_nxt  = opa[31] ^ opb[31];
          end
        end
        default: ;
      endcase
    end else if (busy_r) begin
      if (!trial[48]) begin
        rem_nxt = trial[47:0];
        quo_nxt = {quo_r[46:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[46:0], quo_r[47]};
        quo_nxt = {quo_r[46:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd47) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        res_nxt  = neg_r ? sat32(-64'($signed({16'h0, quo_nxt})))
                         : sat32(64'($signed({16'h0, quo_nxt})));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
    res_r <= res_nxt;
  end

  assign done   = done_r;
  assign result = res_r;

endmodule

// ===== rtl/core/tds_store.sv =====
// Ratio memories: c' and d' with registered read.
module tds_store import tds_pkg::*; (
  input  logic               clk,
  input  logic               we,
  input  logic [IdxW-1:0]    waddr,
  input  logic signed [31:0] wc,
  input  logic signed [31:0] wd,
  input  logic [IdxW-1:0]    raddr,
  output logic signed [31:0] rc,
  output logic signed [31:0] rd
);

  logic signed [31:0] cmem [MaxRows];
  logic signed [31:0] dmem [MaxRows];

  always_ff @(posedge clk) begin
    if (we) begin
      cmem[waddr] <= wc;
      dmem[waddr] <= wd;
    end
    rc <= cmem[raddr];
    rd <= dmem[raddr];
  end

endmodule

// ===== bench/tds_tb_if.sv =====
`timescale 1ns / 100ps
// Testbench-side copies are not needed; this file holds nothing but a helper package.
package tds_tb_pkg;
  typedef struct {
    logic signed [31:0] sub_coef;
    logic signed [31:0] diag_coef;
    logic signed [31:0] super_coef;
    logic signed [31:0] rhs_value;
    logic               last_row;
  } row_req_t;

  typedef struct {
    logic [5:0]         row_index;
    logic signed [31:0] solution;
    logic               final_result;
    logic               singular;
    logic               rows_dropped;
  } sol_req_t;
endpackage

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// Testbench: drives row requests, predicts Thomas-solver solutions, checks outputs.
module tb;
  import tds_pkg::*;
  import tds_tb_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  tds_row_if in_row();
  tds_sol_if out_sol();

  tridiagonal_system_solver_core u_dut (
    .clk(clk), .rst_n(rst_n), .in_row(in_row.sink), .out_sol(out_sol.source)
  );

  localparam int WatchdogLimit = 200000;
  localparam int LongHold = 3000;

  // Predictor state: forward-sweep ratios and per-system flags.
  logic signed [31:0] c_ratio [MaxRows];
  logic signed [31:0] d_ratio [MaxRows];
  int     rows_held;
  logic   piv_zero_seen;
  logic   drop_seen;

  row_req_t row_queue[$];
  sol_req_t sol_expected[$];
  int  mismatches = 0;
  bit  stim_done = 0;
  bit  hold_active = 0;
  int  idle_cycles = 0;

  function automatic logic signed [31:0] clamp32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Rounded Q16.16 product, ties toward +inf (arith shift = floor).
  function automatic logic signed [31:0] fx_mul(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [63:0] t;
    t = 64'(a) * 64'(b) + 64'sd32768;
    return clamp32(t >>> 16);
  endfunction

  function automatic logic signed [31:0] fx_sub(logic signed [31:0] a, logic signed [31:0] b);
    return clamp32(64'(a) - 64'(b));
  endfunction

  // Quotient truncated toward zero, zero divisor saturates by numerator sign.
  function automatic logic signed [31:0] fx_div(logic signed [31:0] n, logic signed [31:0] d);
    logic signed [63:0] num;
    if (d == 0) begin
      if (n > 0) return 32'sh7FFFFFFF;
      if (n < 0) return 32'sh80000000;
      return 32'sd0;
    end
    num = 64'(n) * 64'sd65536;
    return clamp32(num / 64'(d));
  endfunction

  function automatic void solve_row(row_req_t r);
    logic signed [31:0] a, c, piv, x, xprev;
    sol_req_t s;
    int i;
    a = r.sub_coef;
    c = r.super_coef;
    if (rows_held < MaxRows) begin
      i = rows_held;
      if (i == 0) a = 0;
      if (r.last_row) c = 0;
      piv = fx_sub(r.diag_coef, (i == 0) ? 32'sd0 : fx_mul(a, c_ratio[i-1]));
      if (piv == 0) piv_zero_seen = 1;
      c_ratio[i] = fx_div(c, piv);
      d_ratio[i] = fx_div(fx_sub(r.rhs_value, (i == 0) ? 32'sd0 : fx_mul(a, d_ratio[i-1])), piv);
      rows_held = i + 1;
    end else begin
      drop_seen = 1;
    end
    if (!r.last_row) return;
    xprev = 0;
    for (int k = rows_held; k > 0; k--) begin
      if (k == rows_held) x = d_ratio[k-1];
      else x = fx_sub(d_ratio[k-1], fx_mul(c_ratio[k-1], xprev));
      xprev = x;
      s.row_index = 6'(k - 1);
      s.solution = x;
      s.final_result = (k == 1);
      s.singular = piv_zero_seen;
      s.rows_dropped = drop_seen;
      sol_expected.push_back(s);
    end
    rows_held = 0;
    piv_zero_seen = 0;
    drop_seen = 0;
  endfunction

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(0, 9))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'h0;
      3: return $urandom;
      default: return 32'($signed($urandom_range(0, 2**19)) - (2**18));
    endcase
  endfunction

  function automatic void add_row(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                  logic [31:0] d, logic last);
    row_req_t r;
    r.sub_coef = a; r.diag_coef = b; r.super_coef = c; r.rhs_value = d; r.last_row = last;
    row_queue.push_back(r);
  endfunction

  // Random system of n rows, diagonally dominant most of the time.
  function automatic void add_system(int n);
    logic [31:0] b;
    for (int i = 0; i < n; i++) begin
      b = ($urandom_range(0, 7) == 0) ? rand_coef()
                                      : 32'($urandom_range(3 << 16, 9 << 16));
      if ($urandom_range(0, 1)) b = -b;
      add_row(rand_coef(), b, rand_coef(), rand_coef(), i == n - 1);
    end
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  // Driver: offers rows from the queue, gaps on the falling edge.
  int  drv_gap = 0;
  bit  row_taken = 0;
  initial begin
    in_row.valid = 0; in_row.sub_coef = 0; in_row.diag_coef = 0;
    in_row.super_coef = 0; in_row.rhs_value = 0; in_row.last_row = 0;
    out_sol.ready = 0;
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (row_taken) begin
        row_taken = 0;
        void'(row_queue.pop_front());
        drv_gap = gap_len();
      end
      if (drv_gap > 0 || row_queue.size() == 0) begin
        if (drv_gap > 0) drv_gap--;
        in_row.valid <= 0;
      end else begin
        in_row.valid <= 1;
        in_row.sub_coef <= row_queue[0].sub_coef;
        in_row.diag_coef <= row_queue[0].diag_coef;
        in_row.super_coef <= row_queue[0].super_coef;
        in_row.rhs_value <= row_queue[0].rhs_value;
        in_row.last_row <= row_queue[0].last_row;
      end
    end
  end

  // Receiver ready: random stalls, plus one long hold-off.
  int rdy_gap = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_active) out_sol.ready <= 0;
      else if (rdy_gap > 0) begin
        rdy_gap--;
        out_sol.ready <= 0;
      end else begin
        out_sol.ready <= 1;
        rdy_gap = gap_len();
      end
    end
  end

  // Monitor: predicts on accepted rows, checks accepted solutions.
  always @(posedge clk) begin
    sol_req_t e;
    row_req_t r;
    bit progress;
    progress = 0;
    if (rst_n) begin
      if (in_row.valid && in_row.ready) begin
        r.sub_coef = in_row.sub_coef; r.diag_coef = in_row.diag_coef;
        r.super_coef = in_row.super_coef; r.rhs_value = in_row.rhs_value;
        r.last_row = in_row.last_row;
        solve_row(r);
        row_taken = 1;
        progress = 1;
      end
      if (out_sol.valid && out_sol.ready) begin
        progress = 1;
        if (sol_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected solution idx=%0d", out_sol.row_index);
        end else begin
          e = sol_expected.pop_front();
          if (out_sol.row_index !== e.row_index || out_sol.solution !== e.solution ||
              out_sol.final_result !== e.final_result || out_sol.singular !== e.singular ||
              out_sol.rows_dropped !== e.rows_dropped) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch exp idx=%0d x=%h f=%b s=%b d=%b got idx=%0d x=%h f=%b s=%b d=%b",
                       e.row_index, e.solution, e.final_result, e.singular, e.rows_dropped,
                       out_sol.row_index, out_sol.solution, out_sol.final_result,
                       out_sol.singular, out_sol.rows_dropped);
          end
        end
      end
      if (progress) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    int n;
    int m;
    rows_held = 0; piv_zero_seen = 0; drop_seen = 0;
    // Directed: extremes, one-row system, zero pivot, zero numerator.
    add_row(32'h7FFFFFFF, 32'h0001_0000, 32'h7FFFFFFF, 32'h7FFFFFFF, 1);
    add_row(0, 32'h80000000, 0, 32'h80000000, 1);
    add_row(32'hFFFFFFFF, 0, 32'h0001_0000, 32'h0002_0000, 0);
    add_row(32'h0001_0000, 0, 0, 0, 0);
    add_row(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'hFFFF8000, 1);
    add_row(0, 0, 0, 32'hFFFF0000, 1);
    add_row(32'h0000_8000, 32'h0004_0000, 32'h0000_8000, 32'h0001_0000, 0);
    add_row(32'h0000_8000, 32'h0004_0000, 32'h0000_8000, 32'h0001_0000, 1);
    // Overflow: 66 rows, dropped final row still solves.
    add_system(66);
    for (int k = 0; k < 6; k++) add_system($urandom_range(1, 8));
    n = 0;
    while (n < 300) begin
      if ($urandom_range(0, 29) == 0) m = 64;
      else m = $urandom_range(1, 10);
      add_system(m);
      n += m;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1;
    // Long receiver hold-off while rows keep coming.
    repeat (5) @(posedge clk);
    hold_active = 1;
    repeat (LongHold) @(posedge clk);
    hold_active = 0;
    wait (row_queue.size() == 0);
    wait (sol_expected.size() == 0);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && sol_expected.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/core/tds_pkg.sv
rtl/core/tds_if.sv
rtl/core/tds_alu.sv
rtl/core/tds_store.sv
rtl/core/tridiagonal_system_solver_core.sv
bench/tds_tb_if.sv
bench/tb.sv
